### rtl/mh2_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the streaming MurmurHash2 block.
// No dependencies; imported by every other module of the block.
package mh2_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned BYTES_W     = 3;
   localparam int unsigned CSR_ADDR_W  = 3;

   localparam logic [DATA_W-1:0] MIX_MUL    = 32'h5bd1_e995;
   localparam int unsigned       MIX_SHIFT  = 24;
   localparam int unsigned       FIN_SHIFT_A = 13;
   localparam int unsigned       FIN_SHIFT_B = 15;
   localparam logic [DATA_W-1:0] SEED_RESET = 32'h811c_9dc5;

   // Register index, taken from the word address of the APB port.
   localparam logic REG_HASH_SEED = 1'b0;

   localparam logic [BYTES_W-1:0] NBYTES_FULL = 3'd4;
   localparam logic [BYTES_W-1:0] NBYTES_NONE = 3'd0;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_KEY1 = 6'b000010,
      ST_KEY2 = 6'b000100,
      ST_HMIX = 6'b001000,
      ST_TAIL = 6'b010000,
      ST_FIN  = 6'b100000
   } mh2_state_type;

endpackage

### rtl/mh2_mul.sv
`timescale 1ns / 1ps
// Shared multiplier: low 32 bits of the operand times the MurmurHash2 constant.
// Depends on mh2_pkg.
module mh2_mul (
   input  logic [mh2_pkg::DATA_W-1:0] operand,
   output logic [mh2_pkg::DATA_W-1:0] product
);
   import mh2_pkg::*;

   logic [2*DATA_W-1:0] full_product;

   assign full_product = {{DATA_W{1'b0}}, operand} * {{DATA_W{1'b0}}, MIX_MUL};
   assign product      = full_product[DATA_W-1:0];

endmodule

### rtl/mh2_csr.sv
`timescale 1ns / 1ps
// APB-style register file holding the hash seed.
// Depends on mh2_pkg.
module mh2_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mh2_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mh2_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [mh2_pkg::DATA_W-1:0]     csr_prdata,
   output logic                           csr_pready,
   output logic [mh2_pkg::DATA_W-1:0]     hash_seed
);
   import mh2_pkg::*;

   logic [DATA_W-1:0] seed_ff;
   logic [DATA_W-1:0] seed_in;
   logic              reg_index;
   logic              write_hit;

   // Bits 1:0 select a byte within the word and are ignored.
   assign reg_index = csr_paddr[CSR_ADDR_W-1];
   assign write_hit = csr_psel && csr_penable && csr_pwrite && csr_pready
                      && (reg_index == REG_HASH_SEED);

   assign seed_in = write_hit ? csr_pwdata : seed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (reg_index == REG_HASH_SEED) ? seed_ff : '0;
   assign hash_seed  = seed_ff;

endmodule

### rtl/murmur2_hash_stream_top.sv
`timescale 1ns / 1ps
// Top level of the streaming 32-bit MurmurHash2 engine: sequencer and datapath.
// Depends on mh2_pkg, mh2_mul and mh2_csr.

// The block hashes a key that arrives as a stream of little-endian 32-bit
// words, one request per word, and returns one response holding the 32-bit
// MurmurHash2 value after the request marked as the last word. On the first
// word of a key the running hash starts as the seed register XOR the key
// length carried with that word; key length on later words is ignored. All
// words before the last are mixed as full four-byte blocks. On the last word
// the byte count selects the path: four or more bytes take the block mix, one
// to three take the tail mix, and zero skips straight to the final avalanche,
// which is how an empty key is sent. Every multiplication goes through one
// shared 32-bit multiplier that takes one step per clock, so a word that is
// not the last passes through the accepting idle state and three dependent
// multiplies in KEY1, KEY2 and HMIX. A last word with four bytes adds the
// avalanche multiply in FIN; one with one to three bytes takes TAIL and then
// FIN, and an empty one goes from idle to FIN. req_ready is high only while
// the sequencer is idle. The finished hash sits in an output register, so
// the next key can start while the response waits; a later result is held
// in the avalanche step until that register has been emptied. The seed
// register sits at byte address 0 of the APB port and is picked up at the
// first word of each key; changes should be made while the block is idle.
module murmur2_hash_stream_top (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel: one key word per request.
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [mh2_pkg::DATA_W-1:0]     req_key_word,
   input  logic [mh2_pkg::BYTES_W-1:0]    req_valid_bytes,
   input  logic                           req_last_word,
   input  logic [mh2_pkg::DATA_W-1:0]     req_key_length,
   // Response channel: one hash per key.
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [mh2_pkg::DATA_W-1:0]     rsp_hash_value,
   // Configuration port.
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mh2_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mh2_pkg::DATA_W-1:0]     csr_pwdata,
   output logic [mh2_pkg::DATA_W-1:0]     csr_prdata,
   output logic                           csr_pready
);
   import mh2_pkg::*;

   // Sequencer state and the flag telling whether a key is in progress.
   mh2_state_type state_ff, state_in;
   logic          in_key_ff, in_key_in;

   // Working registers. hash_ff doubles as the running hash between words.
   logic [DATA_W-1:0]  word_ff, word_in;
   logic [BYTES_W-1:0] nbytes_ff, nbytes_in;
   logic               last_ff, last_in;
   logic [DATA_W-1:0]  kmix_ff, kmix_in;
   logic [DATA_W-1:0]  hash_ff, hash_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_hash_ff, rsp_hash_in;

   logic [DATA_W-1:0] hash_seed;
   logic [DATA_W-1:0] mul_operand;
   logic [DATA_W-1:0] mul_product;
   logic [DATA_W-1:0] tail_mask;
   logic [DATA_W-1:0] final_hash;
   logic              req_fire;
   logic              out_free;

   mh2_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .hash_seed   (hash_seed)
   );

   mh2_mul u_mul (
      .operand (mul_operand),
      .product (mul_product)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Tail mask keeps the low one, two or three bytes of the last word.
   always_comb begin
      case (nbytes_ff)
         3'd1:    tail_mask = 32'h0000_00ff;
         3'd2:    tail_mask = 32'h0000_ffff;
         default: tail_mask = 32'h00ff_ffff;
      endcase
   end

   // Second half of the avalanche follows the multiply in the same cycle.
   assign final_hash = mul_product ^ (mul_product >> FIN_SHIFT_B);

   always_comb begin
      state_in     = state_ff;
      in_key_in    = in_key_ff;
      word_in      = word_ff;
      nbytes_in    = nbytes_ff;
      last_in      = last_ff;
      kmix_in      = kmix_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      mul_operand  = hash_ff ^ (hash_ff >> FIN_SHIFT_A);

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               word_in   = req_key_word;
               nbytes_in = req_valid_bytes;
               last_in   = req_last_word;
               hash_in   = in_key_ff ? hash_ff : (hash_seed ^ req_key_length);
               // Inner words are always full blocks; counts above four
               // on the last word count as a full block too.
               if (!req_last_word || (req_valid_bytes >= NBYTES_FULL)) begin
                  state_in = ST_KEY1;
               end else if (req_valid_bytes == NBYTES_NONE) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_KEY1: begin
            mul_operand = word_ff;
            kmix_in     = mul_product;
            state_in    = ST_KEY2;
         end
         ST_KEY2: begin
            mul_operand = kmix_ff ^ (kmix_ff >> MIX_SHIFT);
            kmix_in     = mul_product;
            state_in    = ST_HMIX;
         end
         ST_HMIX: begin
            mul_operand = hash_ff;
            hash_in     = mul_product ^ kmix_ff;
            if (last_ff) begin
               state_in = ST_FIN;
            end else begin
               in_key_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_TAIL: begin
            mul_operand = hash_ff ^ (word_ff & tail_mask);
            hash_in     = mul_product;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            // Wait here until the output register can take the hash.
            if (out_free) begin
               hash_in      = final_hash;
               rsp_hash_in  = final_hash;
               rsp_valid_in = 1'b1;
               in_key_in    = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         in_key_ff    <= 1'b0;
         hash_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_key_ff    <= in_key_in;
         hash_ff      <= hash_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      nbytes_ff   <= nbytes_in;
      last_ff     <= last_in;
      kmix_ff     <= kmix_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = rsp_hash_ff;

   // A new response can only come out of the avalanche step.
   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff || rsp_ready) ##1 rsp_valid_ff |-> $past(state_ff == ST_FIN))
      else $error("response raised outside the avalanche step");

   // An empty last word goes straight to the avalanche.
   a_empty_key: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_last_word && (req_valid_bytes == NBYTES_NONE)
      |=> state_ff == ST_FIN)
      else $error("empty last word did not go to the avalanche");

   // An inner word finishes with the key marked as in progress.
   a_inner_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HMIX) && !last_ff |=> in_key_ff && (state_ff == ST_IDLE))
      else $error("inner word did not leave the key in progress");

   // The block does not take a second request while one is in work.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("request accepted while busy");

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming MurmurHash2 block (murmur2_hash_stream_top).
// Depends on mh2_pkg for widths, constants and the seed register index.
// A bit-accurate hash predictor runs beside the DUT and checks every response.
module tb;
   import mh2_pkg::*;

   // Hard stop for the whole run. The slowest correct run is about 800 words,
   // plus sender gaps, response stalls and one long response hold, and the
   // limit is set well above that.
   localparam int CYCLE_LIMIT = 300000;
   // Idle cycles allowed after the last response before a register write or the end.
   localparam int DRAIN_CYCLES = 12;
   // Request and response sides idle in this many cycles out of a hundred.
   localparam int IDLE_PCT = 32;
   // The response side holds off once, for a hold set by HOLD_LEN, after HOLD_AT accepted requests.
   localparam int HOLD_AT  = 250;
   localparam int HOLD_LEN = 400;
   // Neither side idles at random while the accepted-request count is in [CALM_FROM, CALM_TO).
   localparam int CALM_FROM = 450;
   localparam int CALM_TO   = 600;
   // Number of random requests in each of the two random phases, rounded up to whole keys.
   localparam int RANDOM_PER_PHASE = 390;

   // Byte addresses on the APB port. The seed is register 0. The next word has no register.
   localparam logic [CSR_ADDR_W-1:0] ADDR_HASH_SEED = CSR_ADDR_W'(4 * REG_HASH_SEED);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED  = ADDR_HASH_SEED + CSR_ADDR_W'(4);

   // One key word as the request channel carries it. When drain_first is set, the
   // driver holds this request back until every outstanding hash has been returned.
   typedef struct {
      logic [DATA_W-1:0]  word;
      logic [BYTES_W-1:0] nbytes;
      logic               last;
      logic [DATA_W-1:0]  klen;
      bit                 drain_first;
   } key_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [DATA_W-1:0]     req_key_word = '0;
   logic [BYTES_W-1:0]    req_valid_bytes = '0;
   logic                  req_last_word = 1'b0;
   logic [DATA_W-1:0]     req_key_length = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DATA_W-1:0]     rsp_hash_value;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0]     csr_pwdata = '0;
   logic [DATA_W-1:0]     csr_prdata;
   logic                  csr_pready;

   // Requests still to be sent, and hashes predicted but not yet returned.
   key_req_type       req_pending[$];
   logic [DATA_W-1:0] hash_expected[$];

   // The predictor's copy of the block's state and its seed register.
   logic [DATA_W-1:0] seed_copy = SEED_RESET;
   logic [DATA_W-1:0] run_hash  = '0;
   logic              key_open  = 1'b0;

   int  words_sent = 0;      // accepted requests; written with NBAs only
   int  hashes_checked = 0;
   int  rsp_errs = 0;
   int  csr_errs = 0;
   int  seeds_set = 1;
   int  total_queued = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   int  cycle_cnt = 0;
   logic calm;

   assign calm = (words_sent >= CALM_FROM) && (words_sent < CALM_TO);

   murmur2_hash_stream_top u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_key_word    (req_key_word),
      .req_valid_bytes (req_valid_bytes),
      .req_last_word   (req_last_word),
      .req_key_length  (req_key_length),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hash_value  (rsp_hash_value),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // This is the full 4-byte block mix of MurmurHash2. The running hash is
   // multiplied, and the scrambled key word is folded into it.
   function automatic logic [DATA_W-1:0] mix_word(input logic [DATA_W-1:0] h,
                                                  input logic [DATA_W-1:0] k);
      logic [DATA_W-1:0] km;
      km = k * MIX_MUL;
      km = km ^ (km >> MIX_SHIFT);
      km = km * MIX_MUL;
      return (h * MIX_MUL) ^ km;
   endfunction

   // Advances the predicted hash state by one accepted request. On a last word it
   // finishes the hash and queues it as the expected response.
   function void hash_absorb(input key_req_type r);
      logic [DATA_W-1:0] h;
      logic [DATA_W-1:0] mask;
      // The seed and the length count only on the first word of a key.
      h = key_open ? run_hash : (seed_copy ^ r.klen);
      if (!r.last) begin
         // Inner words are always full blocks, whatever their byte count says.
         run_hash = mix_word(h, r.word);
         key_open = 1'b1;
      end else begin
         // Byte counts above four saturate to a full block. Zero adds nothing.
         if (r.nbytes >= NBYTES_FULL) begin
            h = mix_word(h, r.word);
         end else if (r.nbytes != NBYTES_NONE) begin
            mask = {DATA_W{1'b1}} >> (8 * (NBYTES_FULL - r.nbytes));
            h = (h ^ (r.word & mask)) * MIX_MUL;
         end
         h = h ^ (h >> FIN_SHIFT_A);
         h = h * MIX_MUL;
         h = h ^ (h >> FIN_SHIFT_B);
         run_hash = h;
         key_open = 1'b0;
         hash_expected.push_back(h);
      end
   endfunction

   // Request driver. It works through req_pending and keeps valid and payload
   // steady until the request is taken. It idles at random outside the calm window.
   // A request marked drain_first waits until no hash is outstanding.
   always @(posedge clock) begin : req_driver
      bit taken;
      bit offer;
      taken = req_valid && req_ready;
      offer = 1'b0;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (taken) begin
            hash_absorb(req_pending.pop_front());
            words_sent <= words_sent + 1;
         end
         if (!req_valid || taken) begin
            offer = (req_pending.size() != 0) && (calm || $urandom_range(99) >= IDLE_PCT);
            if (offer && req_pending[0].drain_first && hash_expected.size() != 0) begin
               offer = 1'b0;
            end
            req_valid <= offer;
            if (offer) begin
               req_key_word    <= req_pending[0].word;
               req_valid_bytes <= req_pending[0].nbytes;
               req_last_word   <= req_pending[0].last;
               req_key_length  <= req_pending[0].klen;
            end
         end
      end
   end

   // Response monitor. It checks each returned hash against the oldest prediction.
   // It also drives rsp_ready: random stalls, plus one long hold that fills the
   // block and backs up the request side.
   always @(posedge clock) begin : rsp_monitor
      logic [DATA_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (hash_expected.size() == 0) begin
               $error("hash_value with no hash outstanding: actual %h", rsp_hash_value);
               rsp_errs++;
            end else begin
               want = hash_expected.pop_front();
               if (rsp_hash_value !== want) begin
                  $error("hash_value mismatch: expected %h, actual %h", want, rsp_hash_value);
                  rsp_errs++;
               end
            end
            hashes_checked++;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && words_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog: a run that hangs ends here as a failure.
   initial begin : watchdog
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic queue_request(input logic [DATA_W-1:0] word, input int nbytes,
                                input logic last, input logic [DATA_W-1:0] klen,
                                input bit drain_first = 1'b0);
      key_req_type r;
      r.word        = word;
      r.nbytes      = BYTES_W'(nbytes);
      r.last        = last;
      r.klen        = klen;
      r.drain_first = drain_first;
      req_pending.push_back(r);
      total_queued++;
   endtask

   // Queues one random key. Most keys are short, some are long, and the length
   // usually matches the bytes sent. Some keys carry a random length or odd
   // byte counts on inner words. Later words carry a stale or random length.
   task automatic queue_random_key(input bit drain_first);
      int                nwords;
      int                tail;
      int                pick;
      logic [DATA_W-1:0] len;
      logic [DATA_W-1:0] word;
      pick = $urandom_range(99);
      nwords = (pick < 70) ? $urandom_range(1, 4) :
               (pick < 95) ? $urandom_range(5, 12) : $urandom_range(13, 40);
      tail = ($urandom_range(99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 7);
      len = DATA_W'(4 * (nwords - 1) + ((tail > 4) ? 4 : tail));
      if ($urandom_range(99) < 15) begin
         len = $urandom();
      end
      for (int i = 0; i < nwords; i++) begin
         pick = $urandom_range(99);
         word = (pick < 4) ? '0 : (pick < 8) ? '1 : $urandom();
         if (i == nwords - 1) begin
            queue_request(word, tail, 1'b1, (i == 0) ? len : $urandom(), drain_first && i == 0);
         end else begin
            queue_request(word, ($urandom_range(99) < 80) ? 4 : $urandom_range(0, 7), 1'b0,
                          (i == 0 || $urandom_range(1) == 0) ? len : $urandom(),
                          drain_first && i == 0);
         end
      end
   endtask

   // Waits until every queued request is sent and every predicted hash has come
   // back, and then waits a little longer for any inner word still being mixed.
   task automatic wait_quiet();
      do @(negedge clock);
      while (req_pending.size() != 0 || req_valid || hash_expected.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // An APB write has a setup cycle and an access cycle. The register is written
   // at the edge that ends the access cycle.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // An APB read. prdata is sampled in the middle of the access cycle.
   task automatic csr_read_check(input logic [CSR_ADDR_W-1:0] addr,
                                 input logic [DATA_W-1:0] want);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata !== want) begin
         $error("hash_seed readback mismatch: expected %h, actual %h", want, csr_prdata);
         csr_errs++;
      end
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_seed(input logic [DATA_W-1:0] value);
      csr_write(ADDR_HASH_SEED, value);
      seed_copy = value;
      seeds_set++;
      csr_read_check(ADDR_HASH_SEED, value);
   endtask

   // Main sequence: reset, then directed keys, then two random phases. Each phase
   // runs under its own seed. Seed writes happen only after the block has drained.
   initial begin : stimulus
      int target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // The seed must come out of reset at its documented value.
      csr_read_check(ADDR_HASH_SEED, SEED_RESET);

      // Directed keys under the reset seed. First, empty keys: the hash is the
      // avalanche of seed XOR length, and the data word plays no part.
      queue_request(32'h0000_0000, 0, 1'b1, 32'h0000_0000);
      queue_request(32'hffff_ffff, 0, 1'b1, 32'hffff_ffff);
      // Next, one-word keys through every tail size, the full block, and the
      // oversized byte counts that saturate to a full block.
      queue_request(32'hffff_ffff, 1, 1'b1, 32'd1);
      queue_request(32'hffff_ffff, 2, 1'b1, 32'd2);
      queue_request(32'h1234_5678, 3, 1'b1, 32'd3);
      queue_request(32'hffff_ffff, 4, 1'b1, 32'd4);
      queue_request(32'h0000_0000, 5, 1'b1, 32'd4);
      queue_request(32'hdead_beef, 6, 1'b1, 32'd4);
      queue_request(32'hffff_ffff, 7, 1'b1, 32'hffff_ffff);
      // This multi-word key has odd byte counts on its inner words, which must be
      // ignored. Its later words also carry junk lengths.
      queue_request(32'h0302_0100, 0, 1'b0, 32'd11);
      queue_request(32'h0706_0504, 7, 1'b0, 32'hffff_ffff);
      queue_request(32'h000a_0908, 3, 1'b1, 32'd0);
      // The length here disagrees with the bytes actually sent.
      queue_request(32'h0000_0000, 4, 1'b0, 32'd0);
      queue_request(32'hffff_ffff, 4, 1'b1, 32'd0);
      // This key is left open across the next seed write.
      queue_request(32'hcafe_f00d, 4, 1'b0, 32'd6);
      wait_quiet();

      // The seed changes in the middle of a key. The open key must finish on its
      // old start value, and only the keys after it see the new seed.
      set_seed(32'h0000_0000);
      // A write to an address with no register must leave the seed unchanged.
      csr_write(ADDR_UNMAPPED, 32'h5a5a_a5a5);
      csr_read_check(ADDR_HASH_SEED, seed_copy);
      queue_request(32'h0000_beef, 2, 1'b1, 32'hffff_ffff);
      queue_request(32'h1111_1111, 0, 1'b1, 32'd0);
      queue_request(32'h0000_0000, 4, 1'b1, 32'd4);
      queue_request(32'hffff_ffff, 4, 1'b0, 32'd8);
      queue_request(32'hffff_ffff, 4, 1'b1, 32'd8);
      wait_quiet();

      // First random phase, under the all-ones seed. It contains the long
      // response hold. The 21st key and about one key in fifty wait for a full
      // drain before they start.
      set_seed(32'hffff_ffff);
      target = total_queued + RANDOM_PER_PHASE;
      for (int k = 0; total_queued < target; k++) begin
         queue_random_key(k == 20 || $urandom_range(49) == 0);
      end
      wait_quiet();

      // Second random phase, under a random seed. It contains the calm window.
      set_seed($urandom());
      target = total_queued + RANDOM_PER_PHASE;
      for (int k = 0; total_queued < target; k++) begin
         queue_random_key(k == 5 || $urandom_range(49) == 0);
      end
      wait_quiet();

      $display("Checked %0d hashes over %0d request words under %0d seed settings.",
               hashes_checked, words_sent, seeds_set);
      $display("Keys were empty, tail, full and oversized last words, with lengths %s",
               "both matching and not, a mid-key seed change and a long response hold.");
      if (rsp_errs == 0 && csr_errs == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

### sim.f
rtl/mh2_pkg.sv
rtl/mh2_mul.sv
rtl/mh2_csr.sv
rtl/murmur2_hash_stream_top.sv
tb/sv/tb.sv
